// ----- design/vcp_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vcp_pkg - video chip port shared types and constants
// Word layouts of the request and response channels, opcodes, access codes,
// mode register numbers and line timing constants.
// ---------------------------------------------------------------------------
package vcp_pkg;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] data;
        logic       sprite_overflow;
        logic       sprite_collision;
    } req_word_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        irq;
        logic        color_valid;
        logic [4:0]  color_index;
        logic [23:0] color_rgb;
        logic        reg_valid;
        logic [3:0]  reg_index;
        logic [7:0]  reg_value;
        logic        frame_done;
    } rsp_word_t;

    // bus actions
    localparam logic [2:0] OP_READ_CTRL  = 3'd0;
    localparam logic [2:0] OP_WRITE_CTRL = 3'd1;
    localparam logic [2:0] OP_READ_DATA  = 3'd2;
    localparam logic [2:0] OP_WRITE_DATA = 3'd3;
    localparam logic [2:0] OP_READ_VCNT  = 3'd4;
    localparam logic [2:0] OP_READ_HCNT  = 3'd5;
    localparam logic [2:0] OP_LINE_TICK  = 3'd6;

    // access codes from the second control byte
    localparam logic [1:0] CODE_VRAM_READ  = 2'd0;
    localparam logic [1:0] CODE_VRAM_WRITE = 2'd1;
    localparam logic [1:0] CODE_REG_WRITE  = 2'd2;
    localparam logic [1:0] CODE_CRAM_WRITE = 2'd3;

    // mode register numbers
    localparam logic [3:0] REG_MODE0      = 4'd0;
    localparam logic [3:0] REG_MODE1      = 4'd1;
    localparam logic [3:0] REG_NAME_BASE  = 4'd2;
    localparam logic [3:0] REG_SAT_BASE   = 4'd5;
    localparam logic [3:0] REG_SPR_PAT    = 4'd6;
    localparam logic [3:0] REG_BORDER     = 4'd7;
    localparam logic [3:0] REG_HSCROLL    = 4'd8;
    localparam logic [3:0] REG_VSCROLL    = 4'd9;
    localparam logic [3:0] REG_LINE_COUNT = 4'd10;

    localparam logic [7:0] MODE0_MASK  = 8'hF8;
    localparam logic [7:0] MODE1_MASK  = 8'h63;
    localparam logic [7:0] BORDER_MASK = 8'h0F;

    localparam logic [7:0] STATUS_VBLANK    = 8'h80;
    localparam logic [7:0] STATUS_OVERFLOW  = 8'h40;
    localparam logic [7:0] STATUS_COLLISION = 8'h20;
    localparam logic [7:0] HCOUNT_VALUE     = 8'hFF;

    // line timing
    localparam logic [8:0] LAST_LINE      = 9'd261;
    localparam logic [8:0] VBLANK_LINE    = 9'd193;
    localparam logic [8:0] VCOUNT_JUMP    = 9'h0DA;
    localparam logic [8:0] VCOUNT_SKIP    = 9'd6;
    localparam logic [7:0] RASTER_RESET   = 8'hFF;

    // 2-bit color component to 8 bits
    function automatic logic [7:0] expand2(input logic [1:0] v);
        return {v, v, v, v};
    endfunction

endpackage

// ----- design/vcp_req_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vcp_req_if - request channel
// Valid/ready channel carrying one bus action or line tick per word.
// ---------------------------------------------------------------------------
interface vcp_req_if;
    logic              valid;
    logic              ready;
    vcp_pkg::req_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/vcp_rsp_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vcp_rsp_if - response channel
// Valid/ready channel carrying one result word per accepted request.
// ---------------------------------------------------------------------------
interface vcp_rsp_if;
    logic              valid;
    logic              ready;
    vcp_pkg::rsp_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/video_chip_port_and_line_timing_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// video_chip_port_and_line_timing_unit - processor port of a tile video chip
// Address/code latch, read-ahead buffer, video memory, mode registers,
// status flags, line and raster counters.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one word per bus action (control/data port read or write,
//   V/H counter read) or end-of-line tick. rsp returns exactly one word per
//   request: read byte, interrupt line, palette and register write echoes,
//   frame wrap flag.
//   Latency: the response word is registered at the edge that accepts the
//   request and is visible the next cycle.
//   Throughput: one word per cycle, except actions that refill the read-ahead
//   buffer (data port read, address setup with read code): the single-port
//   video memory read is registered and the buffer is loaded from it in a load
//   state, during which req.ready is low. A response word stays in the output
//   register until it is taken; while it waits req.ready is low, unless
//   rsp.ready takes it in that same cycle. Reset clears the latch, flags,
//   counters and mode bits; the raster counter resets to 255. Video memory is
//   not cleared. MEMORY_DEPTH must be a power of two; nothing checks it.
// ---------------------------------------------------------------------------
module video_chip_port_and_line_timing_unit #(
    parameter int MEMORY_DEPTH = 16384
) (
    input  logic            clk,
    input  logic            rst_n,
    vcp_req_if.sink         req,
    vcp_rsp_if.source       rsp
);

    localparam int MEM_AW = $clog2(MEMORY_DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOAD = 1'b1;

    logic state_reg, state_next;

    logic [13:0] addr_reg, addr_next;
    logic [1:0]  code_reg, code_next;
    logic        second_reg, second_next;
    logic [7:0]  ahead_reg, ahead_next;
    logic        vblank_pend_reg, vblank_pend_next;
    logic        raster_pend_reg, raster_pend_next;
    logic        overflow_reg, overflow_next;
    logic        collision_reg, collision_next;
    logic [8:0]  line_reg, line_next;
    logic [7:0]  raster_reg, raster_next;
    logic        line_irq_en_reg, line_irq_en_next;
    logic        vblank_irq_en_reg, vblank_irq_en_next;
    logic [7:0]  raster_reload_reg, raster_reload_next;

    logic               rsp_valid_reg;
    vcp_pkg::rsp_word_t rsp_word_reg;
    vcp_pkg::rsp_word_t rsp_word;

    logic [7:0]        mem [MEMORY_DEPTH];
    logic [7:0]        mem_q_reg;
    logic              mem_we;
    logic              mem_re;
    logic [13:0]       mem_addr;
    logic [MEM_AW-1:0] mem_idx;

    logic       accept;
    logic [7:0] reg_val;
    logic [8:0] vcount_adj;

    assign req.ready   = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept      = req.valid && req.ready;
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_word_reg;

    assign mem_idx    = MEM_AW'(mem_addr);
    assign reg_val    = addr_reg[7:0];
    assign vcount_adj = line_reg - vcp_pkg::VCOUNT_SKIP;

    always_comb
    begin
        state_next         = state_reg;
        addr_next          = addr_reg;
        code_next          = code_reg;
        second_next        = second_reg;
        ahead_next         = ahead_reg;
        vblank_pend_next   = vblank_pend_reg;
        raster_pend_next   = raster_pend_reg;
        overflow_next      = overflow_reg;
        collision_next     = collision_reg;
        line_next          = line_reg;
        raster_next        = raster_reg;
        line_irq_en_next   = line_irq_en_reg;
        vblank_irq_en_next = vblank_irq_en_reg;
        raster_reload_next = raster_reload_reg;
        rsp_word           = '0;
        mem_we             = 1'b0;
        mem_re             = 1'b0;
        mem_addr           = addr_reg;

        // load state of a buffer refill
        if (state_reg == ST_LOAD)
        begin
            ahead_next = mem_q_reg;
            state_next = ST_IDLE;
        end

        if (accept)
        begin
            case (req.payload.opcode)
                vcp_pkg::OP_READ_CTRL:
                begin
                    rsp_word.read_data = (vblank_pend_reg ? vcp_pkg::STATUS_VBLANK : 8'h00)
                                       | (overflow_reg ? vcp_pkg::STATUS_OVERFLOW : 8'h00)
                                       | (collision_reg ? vcp_pkg::STATUS_COLLISION : 8'h00);
                    second_next      = 1'b0;
                    vblank_pend_next = 1'b0;
                    raster_pend_next = 1'b0;
                    overflow_next    = 1'b0;
                    collision_next   = 1'b0;
                end
                vcp_pkg::OP_WRITE_CTRL:
                begin
                    second_next = !second_reg;
                    if (!second_reg)
                    begin
                        addr_next = {addr_reg[13:8], req.payload.data};
                    end
                    else
                    begin
                        code_next = req.payload.data[7:6];
                        mem_addr  = {req.payload.data[5:0], addr_reg[7:0]};
                        addr_next = mem_addr;
                        case (req.payload.data[7:6])
                            vcp_pkg::CODE_VRAM_READ:
                            begin
                                mem_re     = 1'b1;
                                state_next = ST_LOAD;
                                addr_next  = mem_addr + 14'd1;
                            end
                            vcp_pkg::CODE_REG_WRITE:
                            begin
                                // register number comes from the second byte
                                rsp_word.reg_index = req.payload.data[3:0];
                                rsp_word.reg_valid = 1'b1;
                                case (req.payload.data[3:0])
                                    vcp_pkg::REG_MODE0:
                                    begin
                                        line_irq_en_next   = reg_val[4];
                                        rsp_word.reg_value = reg_val & vcp_pkg::MODE0_MASK;
                                    end
                                    vcp_pkg::REG_MODE1:
                                    begin
                                        vblank_irq_en_next = reg_val[5];
                                        rsp_word.reg_value = reg_val & vcp_pkg::MODE1_MASK;
                                    end
                                    vcp_pkg::REG_BORDER:
                                    begin
                                        rsp_word.reg_value = reg_val & vcp_pkg::BORDER_MASK;
                                    end
                                    vcp_pkg::REG_LINE_COUNT:
                                    begin
                                        raster_reload_next = reg_val;
                                        rsp_word.reg_value = reg_val;
                                    end
                                    vcp_pkg::REG_NAME_BASE, vcp_pkg::REG_SAT_BASE,
                                    vcp_pkg::REG_SPR_PAT, vcp_pkg::REG_HSCROLL,
                                    vcp_pkg::REG_VSCROLL:
                                    begin
                                        rsp_word.reg_value = reg_val;
                                    end
                                    default:
                                    begin
                                        rsp_word.reg_valid = 1'b0;
                                        rsp_word.reg_index = 4'd0;
                                    end
                                endcase
                            end
                            default:
                            begin
                                // latch only
                            end
                        endcase
                    end
                end
                vcp_pkg::OP_READ_DATA:
                begin
                    rsp_word.read_data = ahead_reg;
                    second_next        = 1'b0;
                    mem_re             = 1'b1;
                    state_next         = ST_LOAD;
                    addr_next          = addr_reg + 14'd1;
                end
                vcp_pkg::OP_WRITE_DATA:
                begin
                    second_next = 1'b0;
                    ahead_next  = req.payload.data;
                    addr_next   = addr_reg + 14'd1;
                    if (code_reg == vcp_pkg::CODE_CRAM_WRITE)
                    begin
                        rsp_word.color_valid = 1'b1;
                        rsp_word.color_index = addr_reg[4:0];
                        rsp_word.color_rgb   = {vcp_pkg::expand2(req.payload.data[5:4]),
                                                vcp_pkg::expand2(req.payload.data[3:2]),
                                                vcp_pkg::expand2(req.payload.data[1:0])};
                    end
                    else
                    begin
                        mem_we = 1'b1;
                    end
                end
                vcp_pkg::OP_READ_VCNT:
                begin
                    if (line_reg <= vcp_pkg::VCOUNT_JUMP)
                    begin
                        rsp_word.read_data = line_reg[7:0];
                    end
                    else
                    begin
                        rsp_word.read_data = vcount_adj[7:0];
                    end
                end
                vcp_pkg::OP_READ_HCNT:
                begin
                    rsp_word.read_data = vcp_pkg::HCOUNT_VALUE;
                end
                vcp_pkg::OP_LINE_TICK:
                begin
                    overflow_next  = overflow_reg | req.payload.sprite_overflow;
                    collision_next = collision_reg | req.payload.sprite_collision;
                    if (line_reg == vcp_pkg::VBLANK_LINE)
                    begin
                        vblank_pend_next = 1'b1;
                    end
                    if (line_reg < vcp_pkg::VBLANK_LINE)
                    begin
                        // underflow reloads and raises the line interrupt
                        if (raster_reg == 8'd0)
                        begin
                            raster_next      = raster_reload_reg;
                            raster_pend_next = 1'b1;
                        end
                        else
                        begin
                            raster_next = raster_reg - 8'd1;
                        end
                    end
                    else
                    begin
                        raster_next = raster_reload_reg;
                    end
                    if (line_reg >= vcp_pkg::LAST_LINE)
                    begin
                        line_next           = 9'd0;
                        rsp_word.frame_done = 1'b1;
                    end
                    else
                    begin
                        line_next = line_reg + 9'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        rsp_word.irq = (raster_pend_next && line_irq_en_next)
                    || (vblank_pend_next && vblank_irq_en_next);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_idx] <= req.payload.data;
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[mem_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_word_reg <= rsp_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            rsp_valid_reg     <= 1'b0;
            addr_reg          <= '0;
            code_reg          <= '0;
            second_reg        <= 1'b0;
            ahead_reg         <= '0;
            vblank_pend_reg   <= 1'b0;
            raster_pend_reg   <= 1'b0;
            overflow_reg      <= 1'b0;
            collision_reg     <= 1'b0;
            line_reg          <= '0;
            raster_reg        <= vcp_pkg::RASTER_RESET;
            line_irq_en_reg   <= 1'b0;
            vblank_irq_en_reg <= 1'b0;
            raster_reload_reg <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            addr_reg          <= addr_next;
            code_reg          <= code_next;
            second_reg        <= second_next;
            ahead_reg         <= ahead_next;
            vblank_pend_reg   <= vblank_pend_next;
            raster_pend_reg   <= raster_pend_next;
            overflow_reg      <= overflow_next;
            collision_reg     <= collision_next;
            line_reg          <= line_next;
            raster_reg        <= raster_next;
            line_irq_en_reg   <= line_irq_en_next;
            vblank_irq_en_reg <= vblank_irq_en_next;
            raster_reload_reg <= raster_reload_next;
        end
    end

    // no new word while the read-ahead buffer is being refilled
    a_load_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOAD |-> !req.ready)
        else $error("request accepted during buffer refill");

    a_data_read_refills: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.payload.opcode == vcp_pkg::OP_READ_DATA |=> state_reg == ST_LOAD)
        else $error("data port read did not refill read-ahead buffer");

    a_echo_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_word_reg.color_valid && rsp_word_reg.reg_valid))
        else $error("palette and register echo in the same word");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.payload.opcode == vcp_pkg::OP_LINE_TICK
            && line_reg >= vcp_pkg::LAST_LINE
        |=> line_reg == 9'd0 && rsp_word_reg.frame_done)
        else $error("line counter did not wrap with frame_done");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top - self-checking bench for the video chip processor port
// Plans bus accesses and line ticks up front and drives them with random gaps.
// The response side stalls at random. Every response word is compared field
// by field with a shadow of the address latch, read-ahead, mode registers,
// status flags and line/raster counters that is advanced on each accepted word.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int         VRAM_WORDS     = 16384;
    localparam bit         GEN            = 1'b0;   // shadow used while planning words
    localparam bit         CHK            = 1'b1;   // shadow advanced on accepted words
    localparam int         MAX_ERR_PRINTS = 10;
    localparam logic [2:0] OP_UNUSED      = 3'd7;
    localparam logic [3:0] REG_UNMAPPED   = 4'd15;

    typedef struct packed {
        logic [13:0] addr;
        logic [1:0]  code;
        logic        second;
        logic [7:0]  ahead;
        logic        vblank;
        logic        raster;
        logic        ovf;
        logic        coll;
        logic [8:0]  line;
        logic [7:0]  raster_cnt;
        logic [4:0]  mode0;
        logic [3:0]  mode1;
        logic [7:0]  name_base;
        logic [7:0]  sat_base;
        logic [7:0]  spr_pat;
        logic [7:0]  hscroll;
        logic [7:0]  vscroll;
        logic [7:0]  line_count;
        logic [3:0]  border;
        logic [7:0]  vscroll_latch;
    } port_state_t;

    typedef struct packed {
        vcp_pkg::req_word_t w;
        logic               wait_idle;   // hold until all responses are back
    } bus_item_t;

    logic clk = 1'b0;
    logic rst_n;
    bit   live = 1'b0;

    vcp_req_if req_ch ();
    vcp_rsp_if rsp_ch ();

    video_chip_port_and_line_timing_unit #(
        .MEMORY_DEPTH(VRAM_WORDS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    port_state_t shadow [2];
    logic [7:0]  vram_img [2][VRAM_WORDS];
    bit          vram_set [2][VRAM_WORDS];

    bus_item_t          bus_plan [$];
    vcp_pkg::rsp_word_t owed_rsp [$];
    logic [13:0]        vram_addrs [$];   // addresses holding written data

    logic        hold_next = 1'b0;
    int unsigned planned = 0;
    int unsigned frames_planned = 0;

    bit          req_took = 1'b0;
    bit          rsp_took = 1'b0;
    int unsigned words_out = 0;
    int unsigned words_back = 0;
    int unsigned send_wait = 0;
    int unsigned rsp_wait = 0;
    bit          send_calm = 1'b0;
    bit          rsp_calm = 1'b0;

    int unsigned errors = 0;
    int unsigned wraps_seen = 0;
    int unsigned reg_echoes = 0;
    int unsigned color_echoes = 0;
    int unsigned irq_high = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void chip_reset(input bit k);
        shadow[k] = '0;
        shadow[k].raster_cnt = vcp_pkg::RASTER_RESET;
        for (int i = 0; i < VRAM_WORDS; i++)
            vram_set[k][14'(i)] = 1'b0;
    endfunction

    // One bus action or line tick; returns the response word it produces.
    function automatic vcp_pkg::rsp_word_t port_step(input bit k,
                                                     input vcp_pkg::req_word_t w);
        port_state_t        s;
        vcp_pkg::rsp_word_t r;
        logic [7:0]         stored;
        logic [3:0]         rn;
        logic [8:0]         vline;
        logic               known;
        s = shadow[k];
        r = '0;
        case (w.opcode)
            vcp_pkg::OP_READ_CTRL:
            begin
                r.read_data = (s.vblank ? vcp_pkg::STATUS_VBLANK : 8'h00) |
                              (s.ovf ? vcp_pkg::STATUS_OVERFLOW : 8'h00) |
                              (s.coll ? vcp_pkg::STATUS_COLLISION : 8'h00);
                s.second = 1'b0;
                s.vblank = 1'b0;
                s.raster = 1'b0;
                s.ovf    = 1'b0;
                s.coll   = 1'b0;
            end
            vcp_pkg::OP_WRITE_CTRL:
            begin
                if (!s.second)
                begin
                    s.addr[7:0] = w.data;
                end
                else
                begin
                    s.code = w.data[7:6];
                    s.addr[13:8] = w.data[5:0];
                    if (s.code == vcp_pkg::CODE_VRAM_READ)
                    begin
                        s.ahead = vram_img[k][s.addr];
                        s.addr  = s.addr + 14'd1;
                    end
                    else if (s.code == vcp_pkg::CODE_REG_WRITE)
                    begin
                        rn     = s.addr[11:8];
                        stored = s.addr[7:0];
                        known  = 1'b1;
                        case (rn)
                            vcp_pkg::REG_MODE0:
                            begin
                                s.mode0 = stored[7:3];
                                stored  = stored & vcp_pkg::MODE0_MASK;
                            end
                            vcp_pkg::REG_MODE1:
                            begin
                                s.mode1 = {stored[6:5], stored[1:0]};
                                stored  = stored & vcp_pkg::MODE1_MASK;
                            end
                            vcp_pkg::REG_NAME_BASE:  s.name_base  = stored;
                            vcp_pkg::REG_SAT_BASE:   s.sat_base   = stored;
                            vcp_pkg::REG_SPR_PAT:    s.spr_pat    = stored;
                            vcp_pkg::REG_BORDER:
                            begin
                                stored   = stored & vcp_pkg::BORDER_MASK;
                                s.border = stored[3:0];
                            end
                            vcp_pkg::REG_HSCROLL:    s.hscroll    = stored;
                            vcp_pkg::REG_VSCROLL:    s.vscroll    = stored;
                            vcp_pkg::REG_LINE_COUNT: s.line_count = stored;
                            default:                 known        = 1'b0;
                        endcase
                        if (known)
                        begin
                            r.reg_valid = 1'b1;
                            r.reg_index = rn;
                            r.reg_value = stored;
                        end
                    end
                end
                s.second = !s.second;
            end
            vcp_pkg::OP_READ_DATA:
            begin
                r.read_data = s.ahead;
                s.ahead  = vram_img[k][s.addr];
                s.second = 1'b0;
                s.addr   = s.addr + 14'd1;
            end
            vcp_pkg::OP_WRITE_DATA:
            begin
                s.second = 1'b0;
                s.ahead  = w.data;
                if (s.code == vcp_pkg::CODE_CRAM_WRITE)
                begin
                    r.color_valid = 1'b1;
                    r.color_index = s.addr[4:0];
                    r.color_rgb   = {{4{w.data[5:4]}}, {4{w.data[3:2]}}, {4{w.data[1:0]}}};
                end
                else
                begin
                    vram_img[k][s.addr] = w.data;
                    vram_set[k][s.addr] = 1'b1;
                end
                s.addr = s.addr + 14'd1;
            end
            vcp_pkg::OP_READ_VCNT:
            begin
                vline = (s.line <= vcp_pkg::VCOUNT_JUMP) ? s.line
                                                         : s.line - vcp_pkg::VCOUNT_SKIP;
                r.read_data = vline[7:0];
            end
            vcp_pkg::OP_READ_HCNT: r.read_data = vcp_pkg::HCOUNT_VALUE;
            vcp_pkg::OP_LINE_TICK:
            begin
                if (s.line == 9'd0)
                    s.vscroll_latch = s.vscroll;
                if (w.sprite_overflow)
                    s.ovf = 1'b1;
                if (w.sprite_collision)
                    s.coll = 1'b1;
                if (s.line == vcp_pkg::VBLANK_LINE)
                    s.vblank = 1'b1;
                if (s.line < vcp_pkg::VBLANK_LINE)
                begin
                    s.raster_cnt = s.raster_cnt - 8'd1;
                    // underflow reloads and raises the line interrupt
                    if (s.raster_cnt == vcp_pkg::RASTER_RESET)
                    begin
                        s.raster_cnt = s.line_count;
                        s.raster     = 1'b1;
                    end
                end
                else
                begin
                    s.raster_cnt = s.line_count;
                end
                if (s.line >= vcp_pkg::LAST_LINE)
                begin
                    s.line = 9'd0;
                    r.frame_done = 1'b1;
                end
                else
                begin
                    s.line = s.line + 9'd1;
                end
            end
            default: ;
        endcase
        r.irq = (s.raster && s.mode0[1]) || (s.vblank && s.mode1[2]);
        shadow[k] = s;
        return r;
    endfunction

    function automatic string field_diffs(input vcp_pkg::rsp_word_t e,
                                          input vcp_pkg::rsp_word_t g);
        string d;
        d = "";
        if (g.read_data !== e.read_data)
            d = {d, $sformatf(" read_data %02h/%02h", e.read_data, g.read_data)};
        if (g.irq !== e.irq)
            d = {d, $sformatf(" irq %0b/%0b", e.irq, g.irq)};
        if (g.color_valid !== e.color_valid)
            d = {d, $sformatf(" color_valid %0b/%0b", e.color_valid, g.color_valid)};
        if (g.color_index !== e.color_index)
            d = {d, $sformatf(" color_index %0d/%0d", e.color_index, g.color_index)};
        if (g.color_rgb !== e.color_rgb)
            d = {d, $sformatf(" color_rgb %06h/%06h", e.color_rgb, g.color_rgb)};
        if (g.reg_valid !== e.reg_valid)
            d = {d, $sformatf(" reg_valid %0b/%0b", e.reg_valid, g.reg_valid)};
        if (g.reg_index !== e.reg_index)
            d = {d, $sformatf(" reg_index %0d/%0d", e.reg_index, g.reg_index)};
        if (g.reg_value !== e.reg_value)
            d = {d, $sformatf(" reg_value %02h/%02h", e.reg_value, g.reg_value)};
        if (g.frame_done !== e.frame_done)
            d = {d, $sformatf(" frame_done %0b/%0b", e.frame_done, g.frame_done)};
        return d;
    endfunction

    function automatic vcp_pkg::req_word_t mk(input logic [2:0] op, input logic [7:0] d);
        vcp_pkg::req_word_t w;
        w.opcode           = op;
        w.data             = d;
        w.sprite_overflow  = ($urandom_range(0, 7) == 0);
        w.sprite_collision = ($urandom_range(0, 7) == 0);
        return w;
    endfunction

    // Queues a word unless it would read a video memory byte never written.
    function automatic bit plan_word(input vcp_pkg::req_word_t w);
        logic [13:0]        a;
        vcp_pkg::rsp_word_t r;
        a = shadow[GEN].addr;
        if (w.opcode == vcp_pkg::OP_READ_DATA && !vram_set[GEN][a])
            return 1'b0;
        if (w.opcode == vcp_pkg::OP_WRITE_CTRL && shadow[GEN].second &&
            w.data[7:6] == vcp_pkg::CODE_VRAM_READ &&
            !vram_set[GEN][{w.data[5:0], a[7:0]}])
            return 1'b0;
        if (w.opcode == vcp_pkg::OP_WRITE_DATA && shadow[GEN].code != vcp_pkg::CODE_CRAM_WRITE)
            vram_addrs.push_back(a);
        r = port_step(GEN, w);
        if (r.frame_done)
            frames_planned++;
        bus_plan.push_back({w, hold_next});
        hold_next = 1'b0;
        planned++;
        return 1'b1;
    endfunction

    // Two-byte address/code setup; a dangling first byte is flushed first.
    task automatic set_access(input logic [13:0] a, input logic [1:0] c);
        if (shadow[GEN].second)
            void'(plan_word(mk(vcp_pkg::OP_READ_CTRL, 8'($urandom_range(0, 255)))));
        void'(plan_word(mk(vcp_pkg::OP_WRITE_CTRL, a[7:0])));
        if (!plan_word(mk(vcp_pkg::OP_WRITE_CTRL, {c, a[13:8]})))
            void'(plan_word(mk(vcp_pkg::OP_WRITE_CTRL, {vcp_pkg::CODE_VRAM_WRITE, a[13:8]})));
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (!live)
        begin
            req_ch.valid <= 1'b0;
        end
        else if (!req_ch.valid || req_took)
        begin
            if (send_wait != 0)
            begin
                req_ch.valid <= 1'b0;
                send_wait    <= send_wait - 1;
            end
            else if (bus_plan.size() != 0 &&
                     !(bus_plan[0].wait_idle && words_out != words_back))
            begin
                req_ch.valid   <= 1'b1;
                req_ch.payload <= bus_plan[0].w;
                bus_plan.delete(0);
                if ($urandom_range(0, 39) == 0)
                    send_calm <= !send_calm;
                send_wait <= send_calm ? 0 : $urandom_range(0, 8);
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // response ready with random stalls
    always @(negedge clk)
    begin
        if (!live)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (!rsp_ch.ready || rsp_took)
        begin
            if (rsp_wait != 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_wait     <= rsp_wait - 1;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 39) == 0)
                    rsp_calm <= !rsp_calm;
                rsp_wait <= rsp_calm ? 0 : $urandom_range(0, 8);
            end
        end
    end

    // monitor: check responses, then predict for newly accepted requests
    always @(posedge clk)
    begin : watch
        vcp_pkg::rsp_word_t want;
        string              diffs;
        live     <= rst_n;
        req_took <= req_ch.valid && req_ch.ready;
        rsp_took <= rsp_ch.valid && rsp_ch.ready;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            words_back <= words_back + 1;
            if (rsp_ch.payload.frame_done === 1'b1)
                wraps_seen++;
            if (rsp_ch.payload.reg_valid === 1'b1)
                reg_echoes++;
            if (rsp_ch.payload.color_valid === 1'b1)
                color_echoes++;
            if (rsp_ch.payload.irq === 1'b1)
                irq_high++;
            if (owed_rsp.size() == 0)
            begin
                errors++;
                if (errors <= MAX_ERR_PRINTS)
                    $display("unexpected response word %h", rsp_ch.payload);
            end
            else
            begin
                want  = owed_rsp.pop_front();
                diffs = field_diffs(want, rsp_ch.payload);
                if (diffs != "")
                begin
                    errors++;
                    if (errors <= MAX_ERR_PRINTS)
                        $display("response %0d mismatch (expected/actual):%s",
                                 words_back, diffs);
                end
            end
        end
        if (req_ch.valid && req_ch.ready)
        begin
            owed_rsp.push_back(port_step(CHK, req_ch.payload));
            words_out <= words_out + 1;
        end
    end

    initial
    begin
        int                 n;
        int unsigned        pick;
        logic [13:0]        a;
        logic [3:0]         rn;
        logic [7:0]         v;
        vcp_pkg::req_word_t w;

        rst_n = 1'b0;
        chip_reset(GEN);
        chip_reset(CHK);

        // directed: counters, unused opcode, address wrap, registers, palette
        void'(plan_word(mk(vcp_pkg::OP_READ_CTRL, 8'h00)));
        void'(plan_word(mk(vcp_pkg::OP_READ_VCNT, 8'hFF)));
        void'(plan_word(mk(vcp_pkg::OP_READ_HCNT, 8'h00)));
        void'(plan_word(mk(OP_UNUSED, 8'hFF)));
        set_access(14'h3FFE, vcp_pkg::CODE_VRAM_WRITE);
        void'(plan_word(mk(vcp_pkg::OP_WRITE_DATA, 8'h00)));
        void'(plan_word(mk(vcp_pkg::OP_WRITE_DATA, 8'hFF)));
        void'(plan_word(mk(vcp_pkg::OP_WRITE_DATA, 8'hA5)));   // lands at 0000
        set_access(14'h3FFE, vcp_pkg::CODE_VRAM_READ);
        void'(plan_word(mk(vcp_pkg::OP_READ_DATA, 8'h5A)));
        void'(plan_word(mk(vcp_pkg::OP_READ_DATA, 8'hC3)));
        set_access({2'b11, vcp_pkg::REG_MODE0, 8'hFF}, vcp_pkg::CODE_REG_WRITE);
        set_access({2'b00, vcp_pkg::REG_MODE1, 8'hFF}, vcp_pkg::CODE_REG_WRITE);
        set_access({2'b10, REG_UNMAPPED, 8'h81}, vcp_pkg::CODE_REG_WRITE);
        set_access(14'h001F, vcp_pkg::CODE_CRAM_WRITE);
        void'(plan_word(mk(vcp_pkg::OP_WRITE_DATA, 8'hFF)));
        void'(plan_word(mk(vcp_pkg::OP_WRITE_DATA, 8'h00)));   // palette index wraps to 0
        w = mk(vcp_pkg::OP_LINE_TICK, 8'h00);
        w.sprite_overflow  = 1'b1;
        w.sprite_collision = 1'b1;
        void'(plan_word(w));
        void'(plan_word(mk(vcp_pkg::OP_READ_CTRL, 8'h00)));

        // random: mostly well-formed access sequences and tick bursts
        hold_next = 1'b1;
        while ((planned < 400 || frames_planned < 1) && planned < 2000)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 59) == 0)
                hold_next = 1'b1;
            if (pick < 30)
            begin
                n = $urandom_range(1, 40);
                repeat (n)
                    void'(plan_word(mk(vcp_pkg::OP_LINE_TICK, 8'($urandom_range(0, 255)))));
            end
            else if (pick < 45)
            begin
                a = 14'($urandom_range(0, VRAM_WORDS - 1));
                if ($urandom_range(0, 3) != 0)
                    a[13:6] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                set_access(a, vcp_pkg::CODE_VRAM_WRITE);
                repeat ($urandom_range(1, 6))
                    void'(plan_word(mk(vcp_pkg::OP_WRITE_DATA, 8'($urandom_range(0, 255)))));
            end
            else if (pick < 55)
            begin
                if (vram_addrs.size() != 0)
                begin
                    set_access(vram_addrs[$urandom_range(0, vram_addrs.size() - 1)],
                               vcp_pkg::CODE_VRAM_READ);
                    n = $urandom_range(1, 5);
                    while (n > 0 &&
                           plan_word(mk(vcp_pkg::OP_READ_DATA, 8'($urandom_range(0, 255)))))
                        n--;
                end
            end
            else if (pick < 67)
            begin
                rn = 4'($urandom_range(0, 15));
                if ($urandom_range(0, 1) == 1)
                begin
                    case ($urandom_range(0, 2))
                        0:       rn = vcp_pkg::REG_MODE0;
                        1:       rn = vcp_pkg::REG_MODE1;
                        default: rn = vcp_pkg::REG_LINE_COUNT;
                    endcase
                end
                v = 8'($urandom_range(0, 255));
                if (rn == vcp_pkg::REG_LINE_COUNT && $urandom_range(0, 1) == 1)
                    v = 8'($urandom_range(0, 6));   // short raster period
                a = 14'($urandom_range(0, VRAM_WORDS - 1));
                a[11:0] = {rn, v};
                set_access(a, vcp_pkg::CODE_REG_WRITE);
            end
            else if (pick < 75)
            begin
                set_access(14'($urandom_range(0, VRAM_WORDS - 1)), vcp_pkg::CODE_CRAM_WRITE);
                repeat ($urandom_range(1, 4))
                    void'(plan_word(mk(vcp_pkg::OP_WRITE_DATA, 8'($urandom_range(0, 255)))));
            end
            else if (pick < 83)
            begin
                void'(plan_word(mk(vcp_pkg::OP_READ_CTRL, 8'($urandom_range(0, 255)))));
            end
            else if (pick < 88)
            begin
                void'(plan_word(mk($urandom_range(0, 1) ? vcp_pkg::OP_READ_VCNT
                                                        : vcp_pkg::OP_READ_HCNT,
                                   8'($urandom_range(0, 255)))));
            end
            else
            begin
                // noise, including lone control bytes
                void'(plan_word(mk(3'($urandom_range(0, 6)), 8'($urandom_range(0, 255)))));
            end
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (bus_plan.size() != 0 || req_ch.valid !== 1'b0)
            @(posedge clk);
        while (words_back != words_out)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("checked %0d response words, %0d frame wraps", words_back, wraps_seen);
        $display("register echoes %0d, palette echoes %0d, irq high on %0d words",
                 reg_echoes, color_echoes, irq_high);
        if (errors == 0 && owed_rsp.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("%0d mismatching response words, %0d never returned",
                     errors, owed_rsp.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d words accepted, %0d returned", words_out, words_back);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
